FILE: rtl/core/sobs_pkg.sv
// Shared types and constants for the set-of-bounded-stacks block.
// Holds the request/response words, operation and status codes, and the
// control word broadcast to the stack-descriptor cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sobs_pkg;

  // Default sizes of the block
  localparam int MAX_STACKS_DEF   = 16;
  localparam int MAX_CAPACITY_DEF = 16;

  // Field widths fixed by the interface
  localparam int CAP_W   = 5;
  localparam int OP_W    = 2;
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;

  // Broadcast positions and slots are carried at the widest supported size
  localparam int POS_W = 8;
  typedef logic [POS_W-1:0] pos_t;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROP  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] push_value;
    logic [INDEX_W-1:0]        stack_index;
  } req_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic [STAT_W-1:0]         status;
  } rsp_word_t;

  // Fill update applied to the cell at the target position
  typedef enum logic [1:0] {
    CK_NONE    = 2'd0,
    CK_INC     = 2'd1,
    CK_DEC     = 2'd2,
    CK_SET_ONE = 2'd3
  } cell_kind_t;

  // Control word seen by every cell in the chain
  typedef struct packed {
    cell_kind_t kind;
    pos_t       tgt_pos;
    logic       shift;
    pos_t       last_pos;
    pos_t       moved_slot;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/sobs_cell.sv
// One list position of the stack list: holds the physical slot at this
// position and that slot's plate count, and takes its upper neighbor's
// entry when a stack leaves the list. Depends on sobs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sobs_cell #(
  parameter int POS    = 0,
  parameter int SLOT_W = 4,
  parameter int FILL_W = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sobs_pkg::cell_ctl_t ctl,
  input  wire logic [SLOT_W-1:0]   nb_slot,
  input  wire logic [FILL_W-1:0]   nb_fill,
  output logic      [SLOT_W-1:0]   slot,
  output logic      [FILL_W-1:0]   fill
);

  localparam sobs_pkg::pos_t MY_POS = sobs_pkg::pos_t'(POS);

  // Shift down on unlink, otherwise update the fill of the targeted stack
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_W'(POS);
      fill <= '0;
    end else if (ctl.shift) begin
      if (MY_POS >= ctl.tgt_pos && MY_POS < ctl.last_pos) begin
        slot <= nb_slot;
        fill <= nb_fill;
      end else if (MY_POS == ctl.last_pos) begin
        slot <= SLOT_W'(ctl.moved_slot);
        fill <= '0;
      end
    end else if (MY_POS == ctl.tgt_pos) begin
      case (ctl.kind)
        sobs_pkg::CK_INC:     fill <= fill + FILL_W'(1);
        sobs_pkg::CK_DEC:     fill <= fill - FILL_W'(1);
        sobs_pkg::CK_SET_ONE: fill <= FILL_W'(1);
        default:              fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/set_of_bounded_stacks.sv
// Set of bounded stacks: top level with the chain of descriptor cells,
// the plate store, the sequencer and the output register. Depends on
// sobs_pkg and sobs_cell.
// A request word is held, decoded in the execute state, and its result is
// loaded into the output register from the wait state, once that register
// can load. No new word is taken in the execute state, only in idle or wait.
// Reset clears the list (no stacks, identity slot order, zero fills) and the
// capacity; the plate store is not cleared and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module set_of_bounded_stacks #(
  parameter int MAX_STACKS   = sobs_pkg::MAX_STACKS_DEF,
  parameter int MAX_CAPACITY = sobs_pkg::MAX_CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cap_we,
  input  wire logic [sobs_pkg::CAP_W-1:0] cap_data,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire sobs_pkg::req_word_t        req,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output sobs_pkg::rsp_word_t             rsp
);

  localparam int PW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int AW = $clog2(MAX_STACKS + 1);
  localparam int FW = $clog2(MAX_CAPACITY + 1);
  localparam int CW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int EW = (FW > sobs_pkg::CAP_W) ? FW : sobs_pkg::CAP_W;
  localparam int IW = (AW > sobs_pkg::INDEX_W) ? AW : sobs_pkg::INDEX_W;
  localparam int MW = PW + CW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t                           state, state_next;
  logic [sobs_pkg::CAP_W-1:0]       capacity;
  logic [AW-1:0]                    active, active_next;
  sobs_pkg::req_word_t              item;
  logic [sobs_pkg::STAT_W-1:0]      pend_status, status_calc;
  logic                             pend_pop, pop_calc;
  logic [sobs_pkg::VALUE_W-1:0]     rd_data;
  logic [sobs_pkg::VALUE_W-1:0]     mem [2**MW];

  logic [PW-1:0]                    cell_slot [MAX_STACKS];
  logic [FW-1:0]                    cell_fill [MAX_STACKS];
  sobs_pkg::cell_ctl_t              ctl, ctl_calc;

  logic                             exec, load_ok, cap_on;
  logic [EW-1:0]                    cap_w, cap_clamped;
  logic [FW-1:0]                    cap_eff;
  logic [PW-1:0]                    last_idx, new_idx, pop_idx;
  logic [FW-1:0]                    pop_fill;
  logic                             pop_hit;
  logic                             wr_en, rd_en;
  logic [MW-1:0]                    wr_addr, rd_addr;

  assign exec    = (state == S_EXEC);
  assign load_ok = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) || ((state == S_WAIT) && load_ok);

  // Clamp the capacity to the store depth
  assign cap_w       = EW'(capacity);
  assign cap_clamped = (cap_w > EW'(MAX_CAPACITY)) ? EW'(MAX_CAPACITY) : cap_w;
  assign cap_eff     = FW'(cap_clamped);
  assign cap_on      = (cap_eff != '0);

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cap_we) begin
      capacity <= cap_data;
    end
  end

  // Chain of list-position cells
  for (genvar i = 0; i < MAX_STACKS; i++) begin : g_cell
    localparam int NB = (i + 1 < MAX_STACKS) ? i + 1 : i;
    sobs_cell #(
      .POS    (i),
      .SLOT_W (PW),
      .FILL_W (FW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .nb_slot (cell_slot[NB]),
      .nb_fill (cell_fill[NB]),
      .slot    (cell_slot[i]),
      .fill    (cell_fill[i])
    );
  end

  assign last_idx = PW'(active - AW'(1));
  assign new_idx  = PW'(active);
  assign pop_idx  = (item.operation == sobs_pkg::OP_POP) ? last_idx
                                                          : PW'(item.stack_index);
  assign pop_fill = cell_fill[pop_idx];
  assign pop_hit  = cap_on && ((item.operation == sobs_pkg::OP_POP) ?
                               (active != '0) :
                               (IW'(item.stack_index) < IW'(active)));

  // Decode the held word into cell control, store access and status
  always_comb begin
    ctl_calc    = '0;
    active_next = active;
    status_calc = sobs_pkg::ST_EMPTY;
    pop_calc    = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = '0;
    rd_addr     = '0;
    case (item.operation) inside
      sobs_pkg::OP_PUSH: begin
        status_calc = sobs_pkg::ST_DROP;
        if (cap_on) begin
          if (active != '0 && cell_fill[last_idx] < cap_eff) begin
            ctl_calc.kind    = sobs_pkg::CK_INC;
            ctl_calc.tgt_pos = sobs_pkg::pos_t'(last_idx);
            wr_en            = 1'b1;
            wr_addr          = {cell_slot[last_idx], CW'(cell_fill[last_idx])};
            status_calc      = sobs_pkg::ST_OK;
          end else if (active < AW'(MAX_STACKS)) begin
            ctl_calc.kind    = sobs_pkg::CK_SET_ONE;
            ctl_calc.tgt_pos = sobs_pkg::pos_t'(new_idx);
            wr_en            = 1'b1;
            wr_addr          = {cell_slot[new_idx], CW'(0)};
            active_next      = active + AW'(1);
            status_calc      = sobs_pkg::ST_OK;
          end
        end
      end
      sobs_pkg::OP_POP, sobs_pkg::OP_POP_AT: begin
        if (pop_hit) begin
          ctl_calc.kind    = sobs_pkg::CK_DEC;
          ctl_calc.tgt_pos = sobs_pkg::pos_t'(pop_idx);
          rd_en            = 1'b1;
          rd_addr          = {cell_slot[pop_idx], CW'(pop_fill - FW'(1))};
          pop_calc         = 1'b1;
          status_calc      = sobs_pkg::ST_OK;
          // Unlink the stack once its last plate goes
          if (pop_fill == FW'(1)) begin
            ctl_calc.shift      = 1'b1;
            ctl_calc.last_pos   = sobs_pkg::pos_t'(last_idx);
            ctl_calc.moved_slot = sobs_pkg::pos_t'(cell_slot[pop_idx]);
            active_next         = active - AW'(1);
          end
        end
      end
      default: begin
        status_calc = sobs_pkg::ST_EMPTY;
      end
    endcase
  end

  // Drive the cells only in the execute cycle
  assign ctl = exec ? ctl_calc : '0;

  // Plate store: one write and one registered read
  always_ff @(posedge clk) begin
    if (exec && wr_en) begin
      mem[wr_addr] <= item.push_value;
    end
    if (exec && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_WAIT;
      S_WAIT: begin
        if (load_ok) state_next = req_valid ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      active <= '0;
    end else begin
      state <= state_next;
      if (exec) active <= active_next;
    end
  end

  // Hold the word and the pending status
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) item <= req;
    if (exec) begin
      pend_status <= status_calc;
      pend_pop    <= pop_calc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_WAIT && load_ok) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WAIT && load_ok) begin
      rsp.popped_value <= pend_pop ? rd_data : '0;
      rsp.status       <= pend_status;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("sequencer state not one-hot");

  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    active <= AW'(MAX_STACKS)) else $error("stack count above maximum");

  a_no_accept_exec: assert property (@(posedge clk) disable iff (rst)
    exec |-> !req_ready) else $error("word accepted during execute");

  a_active_step: assert property (@(posedge clk) disable iff (rst)
    !exec |=> (active == $past(active))) else $error("stack count moved outside execute");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != sobs_pkg::ST_OK |-> rsp.popped_value == '0)
    else $error("nonzero value on failed word");

endmodule

`default_nettype wire

FILE: sim/set_of_bounded_stacks_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for set_of_bounded_stacks: push, pop and indexed pop
// words with random idling on both sides, checked against a tracked stack list.
// Depends on sobs_pkg and the block's RTL.

module set_of_bounded_stacks_tb;
  import sobs_pkg::*;

  localparam int NUM_SLOTS   = MAX_STACKS_DEF;
  localparam int SLOT_DEPTH  = MAX_CAPACITY_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 137;
  localparam int NUM_PHASES  = 12;
  localparam int LONG_HOLD   = 200;

  // Tracks the stack list and queues the reply each request word should get
  class plate_tracker;
    int unsigned capacity;
    int unsigned live_stacks;
    int unsigned slot_of_pos [NUM_SLOTS];
    int unsigned plates_in [NUM_SLOTS];
    logic [VALUE_W-1:0] plates [NUM_SLOTS*SLOT_DEPTH];
    rsp_word_t expected_replies [$];
    int unsigned errors;

    function new();
      capacity    = 0;
      live_stacks = 0;
      errors      = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_of_pos[i] = i;
        plates_in[i]   = 0;
      end
    endfunction

    // Take the top plate at a list position; unlink the stack if it empties
    function logic [VALUE_W-1:0] lift_top_plate(int unsigned pos);
      int unsigned slot;
      int unsigned depth;
      logic [VALUE_W-1:0] top;
      slot  = slot_of_pos[pos];
      depth = plates_in[slot] - 1;
      top   = plates[slot*SLOT_DEPTH + depth];
      plates_in[slot] = depth;
      if (depth == 0) begin
        for (int unsigned i = pos; i + 1 < live_stacks; i++) begin
          slot_of_pos[i] = slot_of_pos[i+1];
        end
        slot_of_pos[live_stacks-1] = slot;
        live_stacks--;
      end
      return top;
    endfunction

    function void note_word(req_word_t w);
      int unsigned limit;
      int unsigned slot;
      bit placed;
      rsp_word_t reply;
      limit = (capacity > SLOT_DEPTH) ? SLOT_DEPTH : capacity;
      reply.popped_value = '0;
      reply.status       = ST_EMPTY;
      case (w.operation)
        OP_PUSH: begin
          reply.status = ST_DROP;
          if (limit != 0) begin
            placed = 1'b0;
            slot   = 0;
            if (live_stacks != 0) begin
              slot   = slot_of_pos[live_stacks-1];
              placed = (plates_in[slot] < limit);
            end
            // Open a new stack at the end when the last one is full or none is live
            if (!placed && live_stacks < NUM_SLOTS) begin
              slot            = slot_of_pos[live_stacks];
              plates_in[slot] = 0;
              live_stacks++;
              placed = 1'b1;
            end
            if (placed) begin
              plates[slot*SLOT_DEPTH + plates_in[slot]] = w.push_value;
              plates_in[slot]++;
              reply.status = ST_OK;
            end
          end
        end
        OP_POP: begin
          if (limit != 0 && live_stacks != 0) begin
            reply.popped_value = lift_top_plate(live_stacks - 1);
            reply.status       = ST_OK;
          end
        end
        OP_POP_AT: begin
          if (limit != 0 && w.stack_index < live_stacks) begin
            reply.popped_value = lift_top_plate(32'(w.stack_index));
            reply.status       = ST_OK;
          end
        end
        default: begin
        end
      endcase
      expected_replies = {expected_replies, reply};
    endfunction

    function void check_reply(rsp_word_t got);
      rsp_word_t want;
      if (expected_replies.size() == 0) begin
        $error("unexpected reply: popped_value %0d status %0d", got.popped_value, got.status);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.popped_value !== want.popped_value) begin
        $error("popped_value: expected %0d, actual %0d", want.popped_value, got.popped_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cap_we    = 1'b0;
  logic [CAP_W-1:0] cap_data  = '0;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_word_t        req       = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_word_t        rsp;

  plate_tracker tracker = new();
  int unsigned  tx_max_gap   = 10;
  int unsigned  rx_max_stall = 10;
  int unsigned  rx_hold      = 0;
  int unsigned  cycle_count  = 0;

  set_of_bounded_stacks u_top (
    .clk       (clk),
    .rst       (rst),
    .cap_we    (cap_we),
    .cap_data  (cap_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Accept reply words after a random stall, or a long hold when requested
  initial begin : reply_sink
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall   = $urandom_range(0, rx_max_stall) + rx_hold;
      rx_hold = 0;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      tracker.check_reply(rsp);
    end
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input req_word_t w);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    tracker.note_word(w);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                         input logic [INDEX_W-1:0] index);
    req_word_t w;
    w.operation   = op;
    w.push_value  = value;
    w.stack_index = index;
    send_word(w);
  endtask

  // Drop valid and wait until every reply is back
  task automatic settle();
    req_valid <= 1'b0;
    while (tracker.expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    settle();
    repeat (4) @(posedge clk);
    cap_we   <= 1'b1;
    cap_data <= value;
    @(posedge clk);
    cap_we <= 1'b0;
    tracker.capacity = 32'(value);
  endtask

  // Mostly push or pop per the mix; indexed pops mostly hit live positions
  function automatic req_word_t random_word(int unsigned push_pct);
    req_word_t w;
    int unsigned roll;
    roll          = $urandom_range(0, 99);
    w.push_value  = $urandom;
    w.stack_index = INDEX_W'($urandom_range(0, 15));
    if (roll < 3) begin
      w.operation = OP_UNUSED;
    end else if (roll < 3 + push_pct) begin
      w.operation = OP_PUSH;
    end else if (roll < 3 + push_pct + (97 - push_pct) / 2) begin
      w.operation = OP_POP;
    end else begin
      w.operation = OP_POP_AT;
      if (tracker.live_stacks != 0 && $urandom_range(0, 4) != 0) begin
        w.stack_index = INDEX_W'($urandom_range(0, tracker.live_stacks - 1));
      end
    end
    return w;
  endfunction

  initial begin : stimulus
    int unsigned phase_caps [NUM_PHASES];
    int unsigned push_pct;
    phase_caps     = '{1, 4, 2, 16, 31, 0, 3, 17, 1, 0, 5, 0};
    phase_caps[9]  = $urandom_range(1, 31);
    phase_caps[11] = $urandom_range(0, 31);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Disabled after reset: push dropped, pops find nothing
    send_op(OP_PUSH, 32'h7FFF_FFFF, 4'd0);
    send_op(OP_POP, 32'h0, 4'd0);
    send_op(OP_POP_AT, 32'h0, 4'd0);
    send_op(OP_UNUSED, 32'hFFFF_FFFF, 4'hF);

    // Three stacks of two, two and one plates with extreme values
    write_capacity(5'd2);
    send_op(OP_PUSH, 32'h8000_0000, 4'd0);
    send_op(OP_PUSH, 32'h7FFF_FFFF, 4'd0);
    send_op(OP_PUSH, 32'h0000_0000, 4'd0);
    send_op(OP_PUSH, 32'hFFFF_FFFF, 4'd0);
    send_op(OP_PUSH, 32'h5555_5555, 4'd0);
    // Two indexes out of range, then empty a middle stack so later ones move down
    send_op(OP_POP_AT, 32'hAAAA_AAAA, 4'hF);
    send_op(OP_POP_AT, 32'h0, 4'd3);
    send_op(OP_POP_AT, 32'h0, 4'd1);
    send_op(OP_POP_AT, 32'h0, 4'd1);
    send_op(OP_UNUSED, 32'h0, 4'd0);
    send_op(OP_POP, 32'h0, 4'd0);
    send_op(OP_POP_AT, 32'h0, 4'd0);
    send_op(OP_POP, 32'h0, 4'd0);
    // Empty list
    send_op(OP_POP, 32'h0, 4'd0);
    send_op(OP_POP_AT, 32'h0, 4'd0);

    // Random phases over several capacities, including lowered and oversize ones
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p][CAP_W-1:0]);
      tx_max_gap   = (p == 3 || p == 8) ? 0 : 10;
      rx_max_stall = (p == 3 || p == 8) ? 0 : 10;
      push_pct     = (p % 3 == 0) ? 70 : ((p % 3 == 1) ? 45 : 25);
      if (p == 1) rx_hold = LONG_HOLD;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 4 && n == PHASE_WORDS / 2) settle();
        send_word(random_word(push_pct));
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
